// ===== src/lz3tw_pkg.sv =====
`default_nettype none
package lz3tw_pkg;

  localparam int MAX_TAPS_DEF       = 32;
  localparam int PRECISION_BITS_DEF = 22;
  localparam int COORD_BITS_DEF     = 12;

  localparam int LEN_W  = 12;  // configured lengths, first_index
  localparam int NUM_W  = 50;  // divider dividend / quotient
  localparam int DEN_W  = 32;  // divider divisor
  localparam int RAW_W  = 32;  // stored raw weight
  localparam int SINC_W = 26;  // sinc value, Q24 signed, |v| <= 1.0
  localparam int ROT_W  = 28;  // CORDIC x/y/z

  localparam logic [25:0]      PI_Q24      = 26'd52707179;
  localparam logic [23:0]      CORDIC_GAIN = 24'd10188014;
  localparam logic [22:0]      DIV3_RECIP  = 23'd5592406;  // ceil(2^24 / 3)
  localparam logic [NUM_W-1:0] ONE_Q40     = NUM_W'(1) << 40;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_EMPTY    = 2'd1;
  localparam logic [1:0] STATUS_TOO_WIDE = 2'd2;

  localparam logic CFG_INPUT_LENGTH  = 1'b0;
  localparam logic CFG_OUTPUT_LENGTH = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE, ST_CMUL, ST_CDIV, ST_CWAIT, ST_FDIV, ST_FWAIT, ST_SDIV, ST_SWAIT,
    ST_WIN1, ST_WIN2, ST_WIN3, ST_TDIFF, ST_TMUL, ST_TAX, ST_FOLD, ST_THETA,
    ST_ROT, ST_PIMUL, ST_DEN, ST_QWAIT, ST_DIV3, ST_A3, ST_WMUL, ST_WGT,
    ST_ACC, ST_RD, ST_NDIV, ST_NWAIT, ST_OUT
  } state_t;

  // atan(2^-i) in Q24
  function automatic logic [24:0] atan_q24(input logic [4:0] i);
    logic [24:0] v;
    case (i)
      5'd0: v = 25'd13176795;
      5'd1: v = 25'd7778716;
      5'd2: v = 25'd4110060;
      5'd3: v = 25'd2086331;
      5'd4: v = 25'd1047214;
      5'd5: v = 25'd524117;
      5'd6: v = 25'd262123;
      5'd7: v = 25'd131069;
      default: v = 25'd1 << (5'd24 - i);
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== src/lz3tw_div.sv =====
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module lz3tw_div import lz3tw_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dsr;
  logic [DEN_W:0]   shifted;
  logic             fits;

  assign shifted = {rem, quo[NUM_W-1]};
  assign fits    = shifted >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= num;
      rem <= '0;
      dsr <= den;
    end else if (busy) begin
      rem <= fits ? DEN_W'(shifted - {1'b0, dsr}) : shifted[DEN_W-1:0];
      quo <= {quo[NUM_W-2:0], fits};
    end
  end

endmodule
`default_nettype wire

// ===== src/lanczos3_tap_weight_generator.sv =====
`default_nettype none
// Lanczos-3 tap weights, one request at a time; in_stall is high from accept to last result.
// Each request runs setup, a raw-weight pass and a normalizing pass over n taps (n <= MAX_TAPS);
// output stalls hold it; error requests skip both passes, an output length of 0 skips setup too.
// Rate is set by the shared bit-serial divider (3 setup, up to 3 per tap) and the
// 24-step CORDIC (up to 2 per tap), all under one sequencer with one shared multiplier.
// Reset (rst, synchronous): idle, no result pending, both lengths 1, raw sum 0.
module lanczos3_tap_weight_generator import lz3tw_pkg::*; #(
  parameter int MAX_TAPS       = MAX_TAPS_DEF,
  parameter int PRECISION_BITS = PRECISION_BITS_DEF,
  parameter int COORD_BITS     = COORD_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // configuration writes
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [LEN_W-1:0]       cfg_data,
  // request channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [COORD_BITS-1:0]  dst_pixel,
  // result channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [LEN_W-1:0]       first_index,
  output logic [6:0]             tap_count,
  output logic signed [23:0]     tap_weight,
  output logic signed [24:0]     weight_sum,
  output logic [1:0]             status,
  output logic                   is_last
);

  localparam int CW = COORD_BITS + 32;   // center, Q20
  localparam int LW = CW + 2;            // window edges, signed
  localparam int XW = LW - 21;           // integer part of left edge
  localparam int IW = $clog2(MAX_TAPS);  // tap index / memory address

  state_t state, state_next;

  // config
  logic [LEN_W-1:0] ilen, olen;

  // per request setup
  logic [COORD_BITS-1:0] oc;
  logic [CW-1:0]         center;
  logic [31:0]           fs;
  logic [33:0]           fs3;
  logic [20:0]           ss;
  logic signed [LW-1:0]  lo, hic;
  logic [XW-1:0]         xmin_w;
  logic [LEN_W-1:0]      xmax;
  logic [LEN_W-1:0]      xmin;
  logic [6:0]            ntaps;
  logic [IW-1:0]         idx;
  logic                  idx_last;

  // pass 1 datapath
  logic [34:0]              ad;
  logic [21:0]              ax_r, a_cur;
  logic                     sel, neg_s;
  logic [4:0]               it;
  logic signed [ROT_W-1:0]  x, y, z;
  logic signed [SINC_W-1:0] sinc1, sinc2, w_r;
  logic signed [39:0]       raw_sum;

  // raw weight store
  logic signed [RAW_W-1:0] mem [MAX_TAPS];
  logic signed [RAW_W-1:0] mem_q;

  // pass 2
  logic               neg_q;
  logic signed [31:0] qsum;

  // shared multiplier, product registered
  logic signed [35:0] mul_a;
  logic signed [26:0] mul_b;
  logic signed [62:0] prod;

  // shared divider
  logic             div_start, div_done;
  logic [NUM_W-1:0] div_num, div_quo;
  logic [DEN_W-1:0] div_den;

  // control / combinational values
  logic                   load_err, load_tap;
  logic [1:0]             err_code;
  logic signed [23:0]     q_cur;
  logic [23:0]            qmag;
  logic signed [31:0]     qsum_next;
  logic [24:0]            sum_sat;
  logic [19:0]            fold_r;
  logic [24:0]            yc;
  logic [28:0]            den_calc;
  logic [48:0]            den_sum;
  logic [32:0]            pos;
  logic signed [LW:0]     tap_off;
  logic [33:0]            ax;
  logic [LEN_W-1:0]       ntap_w;
  logic [24:0]            wabs;
  logic [30:0]            aden;
  logic [39:0]            rs_abs;
  logic [62:0]            pabs;
  logic [24:0]            wmag;
  logic [24:0]            sq_mag;
  logic signed [ROT_W-1:0] dx, dy, at;

  assign in_stall = (state != ST_IDLE);
  assign idx_last = (7'(idx) == ntaps - 7'd1);

  lz3tw_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // fold sin(pi*a) argument into [0, 1/2]
  always_comb begin
    fold_r = a_cur[19:0];
    if (fold_r > 20'd524288) fold_r = 20'(21'd1048576 - {1'b0, a_cur[19:0]});
  end

  assign yc       = y[ROT_W-1] ? 25'd0 :
                    (y > ROT_W'(25'd16777216)) ? 25'd16777216 : y[24:0];
  assign den_sum  = {1'b0, prod[47:0]} + 49'd524288;
  assign den_calc = den_sum[48:20];
  assign pos      = {13'(xmin) + 13'(idx), 1'b1, 19'd0};
  assign tap_off  = $signed((LW+1)'(pos)) - $signed((LW+1)'(center));
  assign ax       = prod[53:20];
  assign ntap_w   = xmax - xmin_w[LEN_W-1:0];
  assign wabs     = mem_q[RAW_W-1] ? 25'(-mem_q) : mem_q[24:0];
  assign rs_abs   = raw_sum[39] ? 40'(-raw_sum) : 40'(raw_sum);
  assign aden     = rs_abs[30:0];
  assign pabs     = prod[62] ? 63'(-prod) : 63'(prod);
  assign wmag     = pabs[48:24];
  assign sq_mag   = (div_quo > NUM_W'(25'd16777216)) ? 25'd16777216 : div_quo[24:0];
  assign dx       = y >>> it;
  assign dy       = x >>> it;
  assign at       = ROT_W'(atan_q24(it));

  // quantized tap weight for the current tap
  always_comb begin
    qmag  = (div_quo > NUM_W'(24'h800000)) ? 24'h800000 : div_quo[23:0];
    q_cur = '0;
    if (state == ST_NWAIT) begin
      if (neg_q) q_cur = 24'(-qmag);
      else       q_cur = (qmag == 24'h800000) ? 24'sh7FFFFF : qmag;
    end
    qsum_next = qsum + 32'(q_cur);
    if (qsum_next > 32'sd16777215)       sum_sat = 25'h0FFFFFF;
    else if (qsum_next < -32'sd16777216) sum_sat = 25'h1000000;
    else                                 sum_sat = qsum_next[24:0];
  end

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_CMUL: begin
        mul_a = 36'({oc, 1'b1});           // 2*oc + 1
        mul_b = 27'(ilen);
      end
      ST_TMUL: begin
        mul_a = 36'(ad);
        mul_b = 27'(ss);
      end
      ST_FOLD: begin
        mul_a = 36'(fold_r);
        mul_b = 27'(PI_Q24);
      end
      ST_PIMUL: begin
        mul_a = 36'(a_cur);
        mul_b = 27'(PI_Q24);
      end
      ST_DIV3: begin
        mul_a = 36'(ax_r);
        mul_b = 27'(DIV3_RECIP);
      end
      ST_WMUL: begin
        mul_a = 36'(sinc1);
        mul_b = 27'(sinc2);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // divider operand select
  always_comb begin
    div_num = '0;
    div_den = '0;
    case (state)
      ST_CDIV: begin
        div_num = NUM_W'({prod[COORD_BITS+12:0], 19'd0});
        div_den = DEN_W'(olen);
      end
      ST_FDIV: begin
        div_num = NUM_W'({ilen, 20'd0});
        div_den = DEN_W'(olen);
      end
      ST_SDIV: begin
        div_num = ONE_Q40;
        div_den = fs;
      end
      ST_DEN: begin
        div_num = NUM_W'({yc, 24'd0});
        div_den = DEN_W'(den_calc);
      end
      ST_NDIV: begin
        div_num = NUM_W'({wabs, {PRECISION_BITS{1'b0}}, 1'b0}) + NUM_W'(aden);
        div_den = {aden, 1'b0};
      end
      default: begin
        div_num = '0;
        div_den = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // sequencer
  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    load_err   = 1'b0;
    load_tap   = 1'b0;
    err_code   = STATUS_OK;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (olen == '0) begin
            load_err   = 1'b1;
            err_code   = STATUS_EMPTY;
            state_next = ST_OUT;
          end else begin
            state_next = ST_CMUL;
          end
        end
      end
      ST_CMUL:  state_next = ST_CDIV;
      ST_CDIV: begin
        div_start  = 1'b1;
        state_next = ST_CWAIT;
      end
      ST_CWAIT: if (div_done) state_next = ST_FDIV;
      ST_FDIV: begin
        div_start  = 1'b1;
        state_next = ST_FWAIT;
      end
      ST_FWAIT: if (div_done) state_next = ST_SDIV;
      ST_SDIV: begin
        div_start  = 1'b1;
        state_next = ST_SWAIT;
      end
      ST_SWAIT: if (div_done) state_next = ST_WIN1;
      ST_WIN1:  state_next = ST_WIN2;
      ST_WIN2:  state_next = ST_WIN3;
      ST_WIN3: begin
        if (xmin_w >= XW'(xmax)) begin
          load_err   = 1'b1;
          err_code   = STATUS_EMPTY;
          state_next = ST_OUT;
        end else if (ntap_w > LEN_W'(MAX_TAPS)) begin
          load_err   = 1'b1;
          err_code   = STATUS_TOO_WIDE;
          state_next = ST_OUT;
        end else begin
          state_next = ST_TDIFF;
        end
      end
      ST_TDIFF: state_next = ST_TMUL;
      ST_TMUL:  state_next = ST_TAX;
      ST_TAX: begin
        if (ax == '0 || ax >= 34'(23'h300000)) state_next = ST_ACC;
        else                                   state_next = ST_FOLD;
      end
      ST_FOLD:  state_next = ST_THETA;
      ST_THETA: state_next = ST_ROT;
      ST_ROT:   if (it == 5'd23) state_next = ST_PIMUL;
      ST_PIMUL: state_next = ST_DEN;
      ST_DEN: begin
        div_start  = 1'b1;
        state_next = ST_QWAIT;
      end
      ST_QWAIT: begin
        if (div_done) state_next = sel ? ST_WMUL : ST_DIV3;
      end
      ST_DIV3:  state_next = ST_A3;
      ST_A3:    state_next = (prod[44:24] == '0) ? ST_WMUL : ST_FOLD;
      ST_WMUL:  state_next = ST_WGT;
      ST_WGT:   state_next = ST_ACC;
      ST_ACC:   state_next = idx_last ? ST_RD : ST_TDIFF;
      ST_RD:    state_next = ST_NDIV;
      ST_NDIV: begin
        if (raw_sum == '0) begin
          load_tap   = 1'b1;
          state_next = ST_OUT;
        end else begin
          div_start  = 1'b1;
          state_next = ST_NWAIT;
        end
      end
      ST_NWAIT: begin
        if (div_done) begin
          load_tap   = 1'b1;
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_stall) state_next = is_last ? ST_IDLE : ST_RD;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // raw weight store, registered read
  always_ff @(posedge clk) begin
    if (state == ST_ACC) mem[idx] <= RAW_W'(w_r);
    mem_q <= mem[idx];
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      ilen      <= LEN_W'(1);
      olen      <= LEN_W'(1);
      raw_sum   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_INPUT_LENGTH:  ilen <= cfg_data;
          CFG_OUTPUT_LENGTH: olen <= cfg_data;
          default: ;
        endcase
      end

      case (state)
        ST_IDLE:  oc <= dst_pixel;
        ST_CWAIT: if (div_done) center <= div_quo[CW-1:0];
        ST_FWAIT: begin
          if (div_done) begin
            // filter scale never below 1.0
            fs <= (div_quo < NUM_W'(21'h100000)) ? 32'h100000 : div_quo[31:0];
          end
        end
        ST_SDIV:  fs3 <= 34'(fs) + {1'b0, fs, 1'b0};
        ST_SWAIT: if (div_done) ss <= div_quo[20:0];
        ST_WIN1: begin
          lo  <= $signed(LW'(center)) - $signed(LW'(fs3));
          hic <= $signed(LW'(center)) + $signed(LW'(fs3)) + LW'(20'hFFFFF);
        end
        ST_WIN2: begin
          xmin_w <= lo[LW-1] ? '0 : lo[LW-2:20];
          xmax   <= (hic[LW-2:20] > (LW-21)'(ilen)) ? ilen : hic[31:20];
        end
        ST_WIN3: begin
          xmin    <= xmin_w[LEN_W-1:0];
          ntaps   <= 7'(ntap_w);
          idx     <= '0;
          raw_sum <= '0;
          qsum    <= '0;
        end
        // distance of tap center from filter center
        ST_TDIFF: ad <= 35'(tap_off[LW] ? -tap_off : tap_off);
        ST_TAX: begin
          ax_r  <= ax[21:0];
          a_cur <= ax[21:0];
          sel   <= 1'b0;
          if (ax == '0)                      w_r <= 26'sd16777216;
          else if (ax >= 34'(23'h300000))    w_r <= '0;
        end
        ST_FOLD:  neg_s <= a_cur[20];
        ST_THETA: begin
          x  <= ROT_W'(CORDIC_GAIN);
          y  <= '0;
          z  <= ROT_W'(prod[44:20]);
          it <= '0;
        end
        ST_ROT: begin
          if (!z[ROT_W-1]) begin
            x <= x - dx;
            y <= y + dy;
            z <= z - at;
          end else begin
            x <= x + dx;
            y <= y - dy;
            z <= z + at;
          end
          it <= it + 5'd1;
        end
        ST_QWAIT: begin
          if (div_done) begin
            if (sel) sinc2 <= neg_s ? -SINC_W'(sq_mag) : SINC_W'(sq_mag);
            else     sinc1 <= neg_s ? -SINC_W'(sq_mag) : SINC_W'(sq_mag);
          end
        end
        ST_A3: begin
          // second sinc argument is |x| / 3
          a_cur <= 22'(prod[44:24]);
          sel   <= 1'b1;
          if (prod[44:24] == '0) sinc2 <= 26'sd16777216;
        end
        ST_WGT: w_r <= prod[62] ? -SINC_W'(wmag) : SINC_W'(wmag);
        ST_ACC: begin
          raw_sum <= raw_sum + 40'(w_r);
          idx     <= idx_last ? '0 : idx + IW'(1);
        end
        ST_NDIV: neg_q <= mem_q[RAW_W-1] ^ raw_sum[39];
        ST_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            idx       <= idx + IW'(1);
          end
        end
        default: ;
      endcase

      if (load_err) begin
        first_index <= '0;
        tap_count   <= '0;
        tap_weight  <= '0;
        weight_sum  <= '0;
        status      <= err_code;
        is_last     <= 1'b1;
        out_valid   <= 1'b1;
      end else if (load_tap) begin
        first_index <= xmin;
        tap_count   <= ntaps;
        tap_weight  <= q_cur;
        weight_sum  <= idx_last ? sum_sat : '0;
        status      <= STATUS_OK;
        is_last     <= idx_last;
        out_valid   <= 1'b1;
        qsum        <= qsum_next;
      end
    end
  end

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import lz3tw_pkg::*;

  // ---- Q-format constants used by the tap predictor ----
  localparam longint ONE_Q20  = 64'sd1 << 20;
  localparam longint ONE_Q24  = 64'sd1 << 24;
  localparam longint PI_Q     = 64'sd52707179;
  localparam longint GAIN_Q   = 64'sd10188014;
  localparam int     NTAPS    = MAX_TAPS_DEF;
  localparam int     PBITS    = PRECISION_BITS_DEF;
  localparam int     IDLE_LIM = 60000;   // cycles with no handshake before giving up

  typedef struct packed {
    logic [LEN_W-1:0]   first_index;
    logic [6:0]         tap_count;
    logic signed [23:0] tap_weight;
    logic signed [24:0] weight_sum;
    logic [1:0]         status;
    logic               is_last;
  } tap_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_index = CFG_INPUT_LENGTH;
  logic [LEN_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [COORD_BITS_DEF-1:0] dst_pixel = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [LEN_W-1:0] first_index;
  logic [6:0] tap_count;
  logic signed [23:0] tap_weight;
  logic signed [24:0] weight_sum;
  logic [1:0] status;
  logic is_last;

  lanczos3_tap_weight_generator DUT (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .dst_pixel,
    .out_valid, .out_stall, .first_index, .tap_count, .tap_weight,
    .weight_sum, .status, .is_last
  );

  initial forever #6 clk = ~clk;

  // predictor's copy of the configuration
  longint unsigned src_len = 1;
  longint unsigned dst_len = 1;

  tap_result_t pending_taps[$];
  int mismatches = 0;
  int stray_results = 0;
  int requests_sent = 0;
  int results_seen = 0;
  int error_results = 0;
  int max_taps_seen = 0;
  int idle_cycles = 0;

  // ---- predictor ----
  function automatic longint atan_step(int i);
    case (i)
      0: return 13176795;
      1: return 7778716;
      2: return 4110060;
      3: return 2086331;
      4: return 1047214;
      5: return 524117;
      6: return 262123;
      7: return 131069;
      default: return 64'sd1 << (24 - i);
    endcase
  endfunction

  function automatic longint rot_sine(longint theta);
    longint x, y, z, dx, dy;
    x = GAIN_Q; y = 0; z = theta;
    for (int i = 0; i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_step(i);
      end else begin
        x += dx; y -= dy; z += atan_step(i);
      end
    end
    if (y < 0) y = 0;
    if (y > ONE_Q24) y = ONE_Q24;
    return y;
  endfunction

  // normalized sinc of a non-negative Q20 argument, Q24 result
  function automatic longint sinc_val(longint unsigned a);
    longint unsigned m, r, den;
    longint s, q;
    if (a == 0) return ONE_Q24;
    m = a % (2 * ONE_Q20);
    r = m % ONE_Q20;
    if (r > ONE_Q20 / 2) r = ONE_Q20 - r;
    s = rot_sine(longint'((r * PI_Q) >> 20));
    if (m >= ONE_Q20) s = -s;
    den = (a * PI_Q + (64'd1 << 19)) >> 20;
    if (den == 0) return ONE_Q24;
    q = (s * ONE_Q24) / longint'(den);
    if (q > ONE_Q24) q = ONE_Q24;
    if (q < -ONE_Q24) q = -ONE_Q24;
    return q;
  endfunction

  // queue up the expected tap stream for one destination pixel
  task automatic predict_taps(input logic [COORD_BITS_DEF-1:0] coord);
    longint ilen, olen, oc, center, fs, ss, xmin, xmax, n, d, w, num, q, qsum, rsum;
    longint unsigned ad, ax, an, aden, mag;
    longint raw[NTAPS];
    tap_result_t r;
    ilen = src_len; olen = dst_len; oc = coord;
    r = '0;
    r.is_last = 1'b1;
    if (olen == 0) begin
      r.status = STATUS_EMPTY;
      pending_taps.push_back(r);
      return;
    end
    center = ((2 * oc + 1) * ilen * (ONE_Q20 / 2)) / olen;
    fs = (ilen * ONE_Q20) / olen;
    if (fs < ONE_Q20) fs = ONE_Q20;
    ss = (ONE_Q20 * ONE_Q20) / fs;
    xmin = (center - 3 * fs) >>> 20;
    xmax = (center + 3 * fs + ONE_Q20 - 1) >>> 20;
    if (xmin < 0) xmin = 0;
    if (xmax > ilen) xmax = ilen;
    n = xmax - xmin;
    if (n <= 0 || n > NTAPS) begin
      r.status = (n <= 0) ? STATUS_EMPTY : STATUS_TOO_WIDE;
      pending_taps.push_back(r);
      return;
    end
    rsum = 0;
    for (int i = 0; i < n; i++) begin
      d = (xmin + i) * ONE_Q20 + ONE_Q20 / 2 - center;
      ad = (d < 0) ? -d : d;
      ax = (ad * longint'(ss)) >> 20;
      if (ax == 0) w = ONE_Q24;
      else if (ax >= 3 * ONE_Q20) w = 0;
      else w = (sinc_val(ax) * sinc_val(ax / 3)) / ONE_Q24;
      raw[i] = longint'(int'(w));
      rsum += w;
    end
    qsum = 0;
    for (int i = 0; i < n; i++) begin
      q = 0;
      if (rsum != 0) begin
        num = raw[i] * (64'sd1 << PBITS);
        an = (num < 0) ? -num : num;
        aden = (rsum < 0) ? -rsum : rsum;
        mag = (2 * an + aden) / (2 * aden);
        if (mag > (64'd1 << 23)) mag = 64'd1 << 23;
        q = ((num < 0) != (rsum < 0)) ? -longint'(mag) : longint'(mag);
        if (q > (64'sd1 << 23) - 1) q = (64'sd1 << 23) - 1;
      end
      qsum += q;
      r = '0;
      r.first_index = xmin[LEN_W-1:0];
      r.tap_count = n[6:0];
      r.tap_weight = q[23:0];
      if (i == n - 1) begin
        if (qsum > (64'sd1 << 24) - 1) qsum = (64'sd1 << 24) - 1;
        if (qsum < -(64'sd1 << 24)) qsum = -(64'sd1 << 24);
        r.weight_sum = qsum[24:0];
        r.is_last = 1'b1;
      end
      pending_taps.push_back(r);
    end
  endtask

  // ---- result checker, receiver stall pattern, watchdog ----
  int stall_mode = 0;   // 0 none, 1 light, 2 heavy
  int stall_left = 0;

  always @(posedge clk) begin
    tap_result_t got, want;
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIM) begin
        $display("watchdog: no handshake for %0d cycles, %0d results pending",
                 IDLE_LIM, pending_taps.size());
        $display("CHECKS FAILED");
        $finish;
      end
      if (out_valid && !out_stall) begin
        got = '{first_index, tap_count, tap_weight, weight_sum, status, is_last};
        results_seen++;
        if (status != STATUS_OK) error_results++;
        if (tap_count > max_taps_seen) max_taps_seen = tap_count;
        if (pending_taps.size() == 0) begin
          stray_results++;
          if (mismatches + stray_results <= 10)
            $display("unexpected result %p", got);
        end else begin
          want = pending_taps.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches + stray_results <= 10)
              $display("mismatch: expected %p, got %p", want, got);
          end
        end
      end
    end
    // receiver: alternating stretches of no stall, light and heavy stall
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(5, 200);
    end else stall_left--;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // ---- shared driving tasks ----
  int burst_left = 0;

  // one request; in_valid stays high on return inside a burst so a burst runs back to back
  task automatic send_request(input logic [COORD_BITS_DEF-1:0] coord);
    in_valid <= 1'b1;
    dst_pixel <= coord;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_taps(coord);
    requests_sent++;
    if (burst_left > 0) burst_left--;
    else begin
      burst_left = $urandom_range(0, 4);
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  endtask

  task automatic drain;
    while (pending_taps.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);   // settle before touching config
  endtask

  task automatic write_reg(input logic idx, input logic [LEN_W-1:0] val);
    in_valid <= 1'b0;
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    if (idx == CFG_INPUT_LENGTH) src_len = val;
    else dst_len = val;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_lengths(input logic [LEN_W-1:0] ilen, input logic [LEN_W-1:0] olen);
    write_reg(CFG_INPUT_LENGTH, ilen);
    write_reg(CFG_OUTPUT_LENGTH, olen);
  endtask

  // ---- tests ----
  task automatic test_reset_lengths;
    // both lengths reset to 1: a single tap, or empty beyond the image
    send_request(12'd0);
    send_request(12'd4095);
  endtask

  task automatic test_directed;
    set_lengths(12'd4095, 12'd4095);       // unity scale, both borders
    send_request(12'd0);
    send_request(12'd2047);
    send_request(12'd4094);
    send_request(12'd4095);                // past the last destination pixel
    set_lengths(12'd4095, 12'd819);        // 5x down, a wide window that still fits
    send_request(12'd0);
    send_request(12'd409);
    send_request(12'd818);
    set_lengths(12'd4095, 12'd1);          // window far over capacity
    send_request(12'd0);
    send_request(12'd2730);
    set_lengths(12'd1, 12'd4095);          // extreme upscale, one source pixel
    send_request(12'd0);
    send_request(12'd4094);
    set_lengths(12'd7, 12'd3);             // mild downscale, fractional centers
    send_request(12'd1);
    send_request(12'd2);
    send_request(12'd5);                   // center beyond the image, window still overlaps its right edge
    set_lengths(12'd2730, 12'd1365);       // exactly 2x
    send_request(12'd682);
    send_request(12'd1364);
  endtask

  task automatic test_random;
    logic [LEN_W-1:0] ilen, olen;
    int sent;
    sent = 0;
    while (sent < 160) begin
      olen = LEN_W'($urandom_range(1, 4095));
      case ($urandom_range(0, 9))
        0: ilen = LEN_W'($urandom_range(1, 4095));
        1: ilen = LEN_W'($urandom_range(1, 16));
        2: ilen = (olen * 6 > 4095) ? 12'd4095 : LEN_W'(olen * 6);
        default: ilen = LEN_W'($urandom_range(1, (2 * olen > 4095) ? 4095 : 2 * olen));
      endcase
      set_lengths(ilen, olen);
      repeat ($urandom_range(10, 30)) begin
        if ($urandom_range(0, 4) == 0)
          send_request(COORD_BITS_DEF'($urandom_range(0, 4095)));
        else
          send_request(COORD_BITS_DEF'($urandom_range(0, olen - 1)));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_lengths();
    test_directed();
    test_random();
    in_valid <= 1'b0;
    drain();
    repeat (200) @(posedge clk);
    $display("covered %0d pixel requests, %0d tap results (%0d error results, up to %0d taps)",
             requests_sent, results_seen, error_results, max_taps_seen);
    $display("mismatches %0d, unexpected results %0d", mismatches, stray_results);
    if (mismatches == 0 && stray_results == 0 && pending_taps.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== lanczos3_tap_weight_generator.f =====
src/lz3tw_pkg.sv
src/lz3tw_div.sv
src/lanczos3_tap_weight_generator.sv
tb/tb_top.sv
